### sv/diff_drive_odometry_integrator_defines.svh
// ----------------------------------------------------------------------------
// odometry integrator assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, masked during reset
`define DDOI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("odometry check failed");

// next-cycle implication, masked during reset
`define DDOI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("odometry check failed");

`else

`define DDOI_ASSERT_NOW(label, clk, rst, ante, cons)
`define DDOI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### sv/ddoi_pkg.sv
// ----------------------------------------------------------------------------
// odometry integrator package
// widths, fixed-point constants, sequencer types and rounding helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddoi_pkg;

  // state widths
  localparam int ANGLE_BITS = 16;
  localparam int POS_BITS   = 32;
  localparam int CFG_W      = 16;
  localparam int RATE_W     = 16;
  localparam int OUT_POS_W  = 32;

  // shared multiplier: signed operands, full product
  localparam int OP_W   = 33;
  localparam int PROD_W = 2 * OP_W;

  // Q30 sine polynomial
  localparam int Q_FRAC = 30;
  localparam int Q_W    = 31;
  localparam logic [Q_W-1:0] POLY_A  = 31'd1686629713;
  localparam logic [Q_W-1:0] POLY_B  = 31'd688904866;
  localparam logic [Q_W-1:0] POLY_C  = 31'd76016977;
  localparam logic [Q_W-1:0] Q30_ONE = 31'd1073741824;

  // 2^32 / (2 pi)
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;

  // rounding shifts
  localparam int SPEED_SHIFT = 16;
  localparam int MOVE_SHIFT  = 38;
  localparam int TURN_SHIFT  = 56 - ANGLE_BITS;

  // register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_RADIUS         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_OVER_SPACING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME           = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] HALF_RADIUS_RST         = 16'd3329;
  localparam logic [CFG_W-1:0] RADIUS_OVER_SPACING_RST = 16'd12062;
  localparam logic [CFG_W-1:0] STEP_TIME_RST           = 16'd3277;

  // heading quadrants
  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  // saturation limits at product width
  localparam logic signed [PROD_W-1:0] S16_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] S16_MIN = -PROD_W'(32768);
  localparam logic signed [PROD_W-1:0] POS_MAX = (PROD_W'(1) << (POS_BITS - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] POS_MIN = -(PROD_W'(1) << (POS_BITS - 1));
  localparam logic signed [PROD_W-1:0] OUT_MAX = (PROD_W'(1) << (OUT_POS_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] OUT_MIN = -(PROD_W'(1) << (OUT_POS_W - 1));

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // round half up: floor(v / 2^n + 1/2)
  function automatic logic signed [PROD_W-1:0] round_shift(
    input logic signed [PROD_W-1:0] v,
    input int                       n
  );
    logic signed [PROD_W-1:0] bias;
    bias = $signed(PROD_W'(1) << (n - 1));
    return (v + bias) >>> n;
  endfunction

  // clamp to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [15:0] r;
    if (v > S16_MAX) begin
      r = 16'sh7fff;
    end else if (v < S16_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // clamp to the position state range
  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
    logic signed [POS_BITS-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[POS_BITS-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[POS_BITS-1:0];
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

  // clamp a position to the reported width
  function automatic logic signed [OUT_POS_W-1:0] sat_out(input logic signed [POS_BITS-1:0] p);
    logic signed [PROD_W-1:0]    v;
    logic signed [OUT_POS_W-1:0] r;
    v = PROD_W'(p);
    if (v > OUT_MAX) begin
      r = OUT_MAX[OUT_POS_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[OUT_POS_W-1:0];
    end else begin
      r = v[OUT_POS_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/diff_drive_odometry_integrator.sv
// ----------------------------------------------------------------------------
// differential drive odometry integrator
// dead reckoning of x, y and heading from wheel rates, one shared multiplier
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_ready) carries one tick: left_rate and
//   right_rate. Output channel (out_valid / out_ready) returns one item per
//   tick: linear_speed, yaw_rate, updated pos_x, pos_y and heading_out.
//   Config port (cfg_we, cfg_index, cfg_data) writes half_radius,
//   radius_over_spacing and step_time; write only while the block is idle.
//   Datapath: one 33x33 signed multiplier runs fifteen products in sixteen
//   sequencer steps (two interleaved sine polynomials, then speed, yaw and
//   the position and heading updates). A new item is taken only once the
//   sequencer has handed the last result to the output register.
//   The output is a register: the next item is accepted while the last
//   result waits. If the receiver stalls, the sequencer holds its finished
//   result until the output register is free, and in_ready stays low.
//   Reset (synchronous, rst) clears position and heading to zero, restores
//   the register defaults, holds in_ready low and drops out_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "diff_drive_odometry_integrator_defines.svh"

module diff_drive_odometry_integrator
  import ddoi_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [RATE_W-1:0]    left_rate,
  input  logic signed [RATE_W-1:0]    right_rate,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          linear_speed,
  output logic signed [15:0]          yaw_rate,
  output logic signed [OUT_POS_W-1:0] pos_x,
  output logic signed [OUT_POS_W-1:0] pos_y,
  output logic [15:0]                 heading_out
);

  // sequencer steps: each but the last issues one product, each but the first writes back the one before
  localparam logic [3:0] ST_XA_SQ    = 4'd0;
  localparam logic [3:0] ST_XB_SQ    = 4'd1;
  localparam logic [3:0] ST_XA_C     = 4'd2;
  localparam logic [3:0] ST_XB_C     = 4'd3;
  localparam logic [3:0] ST_XA_T     = 4'd4;
  localparam logic [3:0] ST_XB_T     = 4'd5;
  localparam logic [3:0] ST_XA_S     = 4'd6;
  localparam logic [3:0] ST_XB_S     = 4'd7;
  localparam logic [3:0] ST_SPEED    = 4'd8;
  localparam logic [3:0] ST_YAW      = 4'd9;
  localparam logic [3:0] ST_SPEED_DT = 4'd10;
  localparam logic [3:0] ST_YAW_DT   = 4'd11;
  localparam logic [3:0] ST_MOVE_X   = 4'd12;
  localparam logic [3:0] ST_TURN     = 4'd13;
  localparam logic [3:0] ST_MOVE_Y   = 4'd14;
  localparam logic [3:0] ST_LAST     = 4'd15;

  // configuration registers
  logic [CFG_W-1:0] half_radius;
  logic [CFG_W-1:0] radius_over_spacing;
  logic [CFG_W-1:0] step_time;

  // integrator state
  logic signed [POS_BITS-1:0] position_x;
  logic signed [POS_BITS-1:0] position_y;
  logic [ANGLE_BITS-1:0]      heading;

  // sequencer
  state_t     state;
  logic [3:0] step;

  // working registers
  logic signed [RATE_W:0]   sum_lr;
  logic signed [RATE_W:0]   diff_lr;
  logic signed [PROD_W-1:0] prod;
  logic [Q_W-1:0]           xa2;
  logic [Q_W-1:0]           xb2;
  logic [Q_W-1:0]           ta;
  logic [Q_W-1:0]           tb;
  logic [Q_W-1:0]           sa;
  logic signed [31:0]       sn;
  logic signed [31:0]       cs;
  logic signed [15:0]       speed;
  logic signed [15:0]       yaw;
  logic signed [31:0]       sv;
  logic signed [31:0]       sy;

  // combinational datapath
  logic [31:0]              phase;
  logic [1:0]               quad;
  logic [Q_W-1:0]           xa;
  logic [Q_W-1:0]           xb;
  logic [Q_W-1:0]           prod_q;
  logic signed [31:0]       sa_s;
  logic signed [31:0]       sb_s;
  logic signed [OP_W-1:0]   op_a;
  logic signed [OP_W-1:0]   op_b;
  logic signed [PROD_W-1:0] move_sum_x;
  logic signed [PROD_W-1:0] move_sum_y;
  logic signed [PROD_W-1:0] turn_step;
  logic                     out_load;

  // phase of the old heading: quadrant and Q30 fraction
  always_comb begin
    phase  = 32'({heading, 32'd0} >> ANGLE_BITS);
    quad   = phase[31:30];
    xa     = Q_W'(phase[29:0]);
    xb     = Q30_ONE - xa;
    prod_q = prod[Q_FRAC+Q_W-1:Q_FRAC];
    sa_s   = $signed({1'b0, sa});
    sb_s   = $signed({1'b0, prod_q});
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      ST_XA_SQ: begin
        op_a = OP_W'(xa);
        op_b = OP_W'(xa);
      end
      ST_XB_SQ: begin
        op_a = OP_W'(xb);
        op_b = OP_W'(xb);
      end
      ST_XA_C: begin
        op_a = OP_W'(POLY_C);
        op_b = OP_W'(xa2);
      end
      ST_XB_C: begin
        op_a = OP_W'(POLY_C);
        op_b = OP_W'(xb2);
      end
      ST_XA_T: begin
        op_a = OP_W'(ta);
        op_b = OP_W'(xa2);
      end
      ST_XB_T: begin
        op_a = OP_W'(tb);
        op_b = OP_W'(xb2);
      end
      ST_XA_S: begin
        op_a = OP_W'(ta);
        op_b = OP_W'(xa);
      end
      ST_XB_S: begin
        op_a = OP_W'(tb);
        op_b = OP_W'(xb);
      end
      ST_SPEED: begin
        op_a = OP_W'(half_radius);
        op_b = OP_W'(sum_lr);
      end
      ST_YAW: begin
        op_a = OP_W'(radius_over_spacing);
        op_b = OP_W'(diff_lr);
      end
      ST_SPEED_DT: begin
        op_a = OP_W'(step_time);
        op_b = OP_W'(speed);
      end
      ST_YAW_DT: begin
        op_a = OP_W'(step_time);
        op_b = OP_W'(yaw);
      end
      ST_MOVE_X: begin
        op_a = OP_W'(sv);
        op_b = OP_W'(cs);
      end
      ST_TURN: begin
        op_a = OP_W'(sy);
        op_b = OP_W'(INV_TWO_PI);
      end
      ST_MOVE_Y: begin
        op_a = OP_W'(sv);
        op_b = OP_W'(sn);
      end
      ST_LAST: begin
        op_a = '0;
        op_b = '0;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // shared multiplier with registered product
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // rounded position and heading increments
  always_comb begin
    move_sum_x = round_shift(prod, MOVE_SHIFT) + PROD_W'(position_x);
    move_sum_y = round_shift(prod, MOVE_SHIFT) + PROD_W'(position_y);
    turn_step  = round_shift(prod, TURN_SHIFT);
  end

  // write back the product issued in the step before
  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      case (step)
        ST_XB_SQ: xa2 <= prod_q;
        ST_XA_C:  xb2 <= prod_q;
        ST_XB_C:  ta  <= POLY_B - prod_q;
        ST_XA_T:  tb  <= POLY_B - prod_q;
        ST_XB_T:  ta  <= POLY_A - prod_q;
        ST_XA_S:  tb  <= POLY_A - prod_q;
        ST_XB_S:  sa  <= prod_q;
        ST_SPEED: begin
          // quadrant folding of the two quarter sines
          case (quad)
            QUAD_FIRST: begin
              sn <= sa_s;
              cs <= sb_s;
            end
            QUAD_SECOND: begin
              sn <= sb_s;
              cs <= -sa_s;
            end
            QUAD_THIRD: begin
              sn <= -sa_s;
              cs <= -sb_s;
            end
            default: begin
              sn <= -sb_s;
              cs <= sa_s;
            end
          endcase
        end
        ST_YAW:      speed <= sat16(round_shift(prod, SPEED_SHIFT));
        ST_SPEED_DT: yaw   <= sat16(round_shift(prod, SPEED_SHIFT));
        ST_YAW_DT:   sv    <= prod[31:0];
        ST_MOVE_X:   sy    <= prod[31:0];
        default: begin
        end
      endcase
    end
  end

  // integrator state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x          <= '0;
      position_y          <= '0;
      heading             <= '0;
      half_radius         <= HALF_RADIUS_RST;
      radius_over_spacing <= RADIUS_OVER_SPACING_RST;
      step_time           <= STEP_TIME_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HALF_RADIUS:         half_radius         <= cfg_data;
          REG_RADIUS_OVER_SPACING: radius_over_spacing <= cfg_data;
          REG_STEP_TIME:           step_time           <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == S_CALC) begin
        case (step)
          ST_TURN:   position_x <= sat_pos(move_sum_x);
          ST_MOVE_Y: heading    <= heading + turn_step[ANGLE_BITS-1:0];
          ST_LAST:   position_y <= sat_pos(move_sum_y);
          default: begin
          end
        endcase
      end
    end
  end

  // wheel sum and difference latched on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sum_lr  <= (RATE_W+1)'(left_rate) + (RATE_W+1)'(right_rate);
      diff_lr <= (RATE_W+1)'(right_rate) - (RATE_W+1)'(left_rate);
    end
  end

  assign in_ready = (state == S_IDLE) && !rst;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (in_valid) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          step <= step + 4'd1;
          if (step == ST_LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      linear_speed <= speed;
      yaw_rate     <= yaw;
      pos_x        <= sat_out(position_x);
      pos_y        <= sat_out(position_y);
      heading_out  <= 16'({heading, 16'd0} >> ANGLE_BITS);
    end
  end

  // checks
  `DDOI_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, (state == S_CALC) && (step == ST_XA_SQ))
  `DDOI_ASSERT_NOW(a_busy_not_ready, clk, rst, state != S_IDLE, !in_ready)
  `DDOI_ASSERT_NEXT(a_last_step_done, clk, rst, (state == S_CALC) && (step == ST_LAST), state == S_DONE)
  `DDOI_ASSERT_NOW(a_result_from_done, clk, rst, $rose(out_valid), $past(state) == S_DONE)

endmodule
